@@ sv/rspm_pkg.sv @@
package rspm_pkg;

  // Command codes of the input transaction.
  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_REPORT = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  // Configuration register indexes.
  localparam logic REG_HIST_SIZE = 1'b0;
  localparam logic REG_PERCENT   = 1'b1;

  localparam int CFG_W = 9;

  // Reset values of the configuration registers.
  localparam logic [8:0] HIST_SIZE_RST = 9'd256;
  localparam logic [6:0] PERCENT_RST   = 7'd50;
  localparam logic [6:0] PERCENT_FULL  = 7'd100;

  // Clamp limits of the Q.8 mean.
  localparam logic [23:0] AVG_POS_MAX = 24'd8388352;
  localparam logic [23:0] AVG_NEG_MAG = 24'd8388608;

  // Rounded percentile index: k = ((n - 1) * 2 * pct + 100) / 200.
  localparam int PCT_ROUND = 100;
  localparam int PCT_DEN   = 200;

  // Division by 200 is a shift by 3 followed by a reciprocal multiply for 25.
  // The reciprocal is ceil(2^32 / 25) and is exact for numerators below 2^30.
  localparam int          PCT_PRE_SH   = 3;
  localparam int          PCT_RECIP_SH = 32;
  localparam logic [31:0] PCT_RECIP    = 32'd171798692;

  // Square root unit works on the Q.16 variance.
  localparam int QW       = 48;
  localparam int SQ_STEPS = 24;
  localparam int DEV_W    = 24;

  // Divider divisor width (sample count is the widest divisor).
  localparam int DIVW = 32;

  typedef struct packed {
    logic [1:0]          cmd;
    logic signed [15:0]  sample;
  } in_t;

  typedef struct packed {
    logic [31:0]         sample_count;
    logic signed [47:0]  sample_total;
    logic signed [15:0]  smallest;
    logic signed [15:0]  largest;
    logic signed [23:0]  average;
    logic [23:0]         deviation;
    logic signed [23:0]  percentile_value;
  } out_t;

endpackage

@@ sv/running_stats_percentile_monitor.sv @@
// Add and clear transactions complete while the sequencer is idle and may follow back to back.
// A report is paced by the shared bit-serial divider, whose width DVW is 66 at the
// default depth, and by the single read port of the history memory.
// Synchronous active-low reset clears all statistics and restores the registers
// (history size 256, percentile 50); the history memory itself is not cleared.
module running_stats_percentile_monitor #(
  parameter int HISTORY_DEPTH = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  rspm_pkg::in_t         in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output rspm_pkg::out_t        out_data,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [rspm_pkg::CFG_W-1:0] cfg_wdata
);
  import rspm_pkg::*;

  localparam int AW   = $clog2(HISTORY_DEPTH);
  localparam int NW   = $clog2(HISTORY_DEPTH + 1);
  localparam int S1W  = 16 + NW;
  localparam int S2W  = 32 + NW;
  localparam int DW   = 32 + 2 * NW;
  localparam int DVW  = (48 + 2 * NW > 56) ? 48 + 2 * NW : 56;
  localparam int DCW  = $clog2(DVW + 1);
  localparam int KNW  = NW + 9;
  localparam int KPW  = KNW + 32;
  localparam logic [NW-1:0] DEPTH_N = NW'(HISTORY_DEPTH);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_MDIV    = 4'd1;
  localparam logic [3:0] S_SUM     = 4'd2;
  localparam logic [3:0] S_DMUL    = 4'd3;
  localparam logic [3:0] S_DSUB    = 4'd4;
  localparam logic [3:0] S_VDIV    = 4'd5;
  localparam logic [3:0] S_SQRT    = 4'd6;
  localparam logic [3:0] S_KDIV    = 4'd7;
  localparam logic [3:0] S_SEL_C   = 4'd8;
  localparam logic [3:0] S_SEL_CW  = 4'd9;
  localparam logic [3:0] S_SEL_SW  = 4'd10;
  localparam logic [3:0] S_OUT     = 4'd11;

  // Configuration and statistics registers.
  logic [8:0]            hsize_r;
  logic [6:0]            pct_r;
  logic [NW-1:0]         wp_r;
  logic [NW-1:0]         fill_r;
  logic [31:0]           cnt_r;
  logic signed [47:0]    tot_r;
  logic signed [15:0]    min_r;
  logic signed [15:0]    max_r;

  // Report sequencer.
  logic [3:0]            state_r;
  logic [NW-1:0]         n_r;
  logic [NW-1:0]         idx_r;
  logic [NW-1:0]         i_r;
  logic [NW-1:0]         k_r;
  logic [KNW-1:0]        knum_r;
  logic [NW-1:0]         lt_r;
  logic [NW-1:0]         le_r;
  logic                  rv1_r;
  logic                  rv2_r;
  logic signed [15:0]    x2_r;
  logic signed [31:0]    sq_r;
  logic signed [S1W-1:0] s1_r;
  logic [S2W-1:0]        s2_r;
  logic [DW-1:0]         ns2_r;
  logic signed [DW-1:0]  s1sq_r;
  logic signed [15:0]    cand_r;
  logic signed [23:0]    avg_r;
  logic [DEV_W-1:0]      dev_r;
  logic signed [23:0]    pv_r;

  // Shared bit-serial divider.
  logic [DVW-1:0]        dvd_r;
  logic [DIVW:0]         rem_r;
  logic [DIVW-1:0]       dsr_r;
  logic [DCW-1:0]        dcnt_r;

  // Square root unit.
  logic [QW-1:0]         sv_r;
  logic [QW-1:0]         sres_r;
  logic [QW-1:0]         sbit_r;
  logic [4:0]            scnt_r;

  // History memory.
  logic signed [15:0]    hist_mem [HISTORY_DEPTH];
  logic signed [15:0]    mem_q_r;

  logic                  out_valid_r;
  out_t                  out_data_r;

  // Combinational helpers.
  logic [15:0]           hs_ext;
  logic [NW-1:0]         size_eff;
  logic                  in_acc;
  logic [NW-1:0]         wp0;
  logic [NW-1:0]         wp1;
  logic                  hist_we;
  logic [AW-1:0]         rd_addr;
  logic signed [48:0]    tot_sum;
  logic [47:0]           tot_abs;
  logic [DW-1:0]         dvar;
  logic [KNW-1:0]        knum;
  logic [KPW-1:0]        kprod;
  logic [DIVW:0]         rem_sh;
  logic                  div_ge;
  logic [QW-1:0]         sq_t;
  logic signed [23:0]    avg_val;
  logic                  sel_hit;

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Effective history size is the register clamped to the memory depth.
  always_comb begin
    hs_ext = {7'd0, hsize_r};
    if (hs_ext > 16'(HISTORY_DEPTH)) begin
      size_eff = DEPTH_N;
    end else begin
      size_eff = hs_ext[NW-1:0];
    end
  end

  // Ring write position for an added sample.
  always_comb begin
    wp0 = (wp_r >= size_eff) ? '0 : wp_r;
    wp1 = wp0 + 1'b1;
    if (wp1 >= size_eff) begin
      wp1 = '0;
    end
  end

  assign hist_we = in_acc && (in_data.cmd == CMD_ADD) && (size_eff != '0);
  assign rd_addr = (state_r == S_SEL_C) ? i_r[AW-1:0] : idx_r[AW-1:0];

  // Saturating total and the magnitude of the total for the mean.
  assign tot_sum = {tot_r[47], tot_r} + 49'(in_data.sample);
  assign tot_abs = tot_r[47] ? 48'(-tot_r) : 48'(tot_r);

  // Scaled variance numerator n*S2 - S1*S1 (never negative).
  assign dvar = ns2_r - DW'(s1sq_r);
  assign knum = KNW'(n_r - 1'b1) * KNW'(pct_r) * KNW'(2) + KNW'(PCT_ROUND);

  // Percentile index: the registered numerator divided by 200.
  assign kprod = KPW'(knum_r >> PCT_PRE_SH) * KPW'(PCT_RECIP);

  // One restoring division step per cycle.
  assign rem_sh = {rem_r[DIVW-1:0], dvd_r[DVW-1]};
  assign div_ge = rem_sh >= {1'b0, dsr_r};

  assign sq_t = sres_r + sbit_r;

  // Mean in Q.8 from the finished quotient, signed and clamped.
  always_comb begin
    if (cnt_r == '0) begin
      avg_val = '0;
    end else if (tot_r[47]) begin
      if (dvd_r > DVW'(AVG_NEG_MAG)) begin
        avg_val = -$signed(AVG_NEG_MAG);
      end else begin
        avg_val = -$signed(dvd_r[23:0]);
      end
    end else if (dvd_r > DVW'(AVG_POS_MAX)) begin
      avg_val = $signed(AVG_POS_MAX);
    end else begin
      avg_val = $signed(dvd_r[23:0]);
    end
  end

  assign sel_hit = ((lt_r <= k_r) && (k_r < le_r)) || (i_r == n_r - 1'b1);

  // History memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[wp0[AW-1:0]] <= in_data.sample;
    end
    mem_q_r <= hist_mem[rd_addr];
  end

  // Divider and square root datapath.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcnt_r <= '0;
      scnt_r <= '0;
    end else begin
      if (dcnt_r != '0) begin
        rem_r  <= div_ge ? rem_sh - {1'b0, dsr_r} : rem_sh;
        dvd_r  <= {dvd_r[DVW-2:0], div_ge};
        dcnt_r <= dcnt_r - 1'b1;
      end
      if (scnt_r != '0) begin
        if (sv_r >= sq_t) begin
          sv_r   <= sv_r - sq_t;
          sres_r <= (sres_r >> 1) + sbit_r;
        end else begin
          sres_r <= sres_r >> 1;
        end
        sbit_r <= sbit_r >> 2;
        scnt_r <= scnt_r - 1'b1;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc && (in_data.cmd == CMD_REPORT) && (cnt_r != '0)) begin
            dvd_r  <= DVW'({tot_abs, 8'd0});
            dsr_r  <= cnt_r;
            rem_r  <= '0;
            dcnt_r <= DCW'(DVW);
          end
        end
        S_DSUB: begin
          dvd_r  <= DVW'({dvar, 16'd0});
          dsr_r  <= DIVW'(n_r) * DIVW'(n_r);
          rem_r  <= '0;
          dcnt_r <= DCW'(DVW);
        end
        S_VDIV: begin
          if (dcnt_r == '0) begin
            sv_r   <= dvd_r[QW-1:0];
            sres_r <= '0;
            sbit_r <= QW'(1) << (QW - 2);
            scnt_r <= 5'(SQ_STEPS);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Statistics, configuration and report sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hsize_r     <= HIST_SIZE_RST;
      pct_r       <= PERCENT_RST;
      wp_r        <= '0;
      fill_r      <= '0;
      cnt_r       <= '0;
      tot_r       <= '0;
      min_r       <= '0;
      max_r       <= '0;
      state_r     <= S_IDLE;
      rv1_r       <= 1'b0;
      rv2_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end

      // Configuration writes; a new history size clears the statistics.
      if (cfg_we) begin
        if (cfg_index == REG_HIST_SIZE) begin
          hsize_r <= cfg_wdata[8:0];
          wp_r    <= '0;
          fill_r  <= '0;
          cnt_r   <= '0;
          tot_r   <= '0;
          min_r   <= '0;
          max_r   <= '0;
        end else if (cfg_index == REG_PERCENT) begin
          pct_r <= cfg_wdata[6:0];
        end
      end

      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            case (in_data.cmd)
              CMD_ADD: begin
                if (cnt_r == '0) begin
                  min_r <= in_data.sample;
                  max_r <= in_data.sample;
                end else begin
                  if (in_data.sample < min_r) min_r <= in_data.sample;
                  if (in_data.sample > max_r) max_r <= in_data.sample;
                end
                if (tot_sum[48] != tot_sum[47]) begin
                  tot_r <= tot_sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
                end else begin
                  tot_r <= tot_sum[47:0];
                end
                if (cnt_r != '1) cnt_r <= cnt_r + 1'b1;
                if (size_eff != '0) begin
                  wp_r <= wp1;
                  if (fill_r < size_eff) fill_r <= fill_r + 1'b1;
                end
              end
              CMD_CLEAR: begin
                wp_r   <= '0;
                fill_r <= '0;
                cnt_r  <= '0;
                tot_r  <= '0;
                min_r  <= '0;
                max_r  <= '0;
              end
              CMD_REPORT: begin
                n_r     <= (fill_r < size_eff) ? fill_r : size_eff;
                state_r <= S_MDIV;
              end
              default: begin
              end
            endcase
          end
        end

        // Mean; an empty history finishes the report here.
        S_MDIV: begin
          if (dcnt_r == '0) begin
            avg_r <= avg_val;
            if (n_r == '0) begin
              dev_r   <= '0;
              pv_r    <= avg_val;
              state_r <= S_OUT;
            end else begin
              idx_r   <= '0;
              rv1_r   <= 1'b0;
              rv2_r   <= 1'b0;
              s1_r    <= '0;
              s2_r    <= '0;
              state_r <= S_SUM;
            end
          end
        end

        // Sweep the history: read, square, accumulate.
        S_SUM: begin
          if (idx_r != n_r) begin
            idx_r <= idx_r + 1'b1;
            rv1_r <= 1'b1;
          end else begin
            rv1_r <= 1'b0;
          end
          rv2_r <= rv1_r;
          if (rv1_r) begin
            x2_r <= mem_q_r;
            sq_r <= mem_q_r * mem_q_r;
          end
          if (rv2_r) begin
            s1_r <= s1_r + S1W'(x2_r);
            s2_r <= s2_r + S2W'(sq_r);
          end
          if ((idx_r == n_r) && !rv1_r && !rv2_r) begin
            state_r <= S_DMUL;
          end
        end

        S_DMUL: begin
          ns2_r   <= n_r * s2_r;
          s1sq_r  <= s1_r * s1_r;
          state_r <= S_DSUB;
        end

        S_DSUB: begin
          state_r <= S_VDIV;
        end

        S_VDIV: begin
          if (dcnt_r == '0) begin
            state_r <= S_SQRT;
          end
        end

        // Deviation done; pick the percentile source.
        S_SQRT: begin
          if (scnt_r == '0) begin
            dev_r <= sres_r[DEV_W-1:0];
            if (pct_r == '0) begin
              pv_r    <= {min_r, 8'd0};
              state_r <= S_OUT;
            end else if (pct_r >= PERCENT_FULL) begin
              pv_r    <= {max_r, 8'd0};
              state_r <= S_OUT;
            end else begin
              knum_r  <= knum;
              state_r <= S_KDIV;
            end
          end
        end

        // Rank index from the reciprocal product.
        S_KDIV: begin
          k_r     <= kprod[PCT_RECIP_SH +: NW];
          i_r     <= '0;
          state_r <= S_SEL_C;
        end

        S_SEL_C: begin
          state_r <= S_SEL_CW;
        end

        S_SEL_CW: begin
          cand_r  <= mem_q_r;
          idx_r   <= '0;
          lt_r    <= '0;
          le_r    <= '0;
          rv1_r   <= 1'b0;
          state_r <= S_SEL_SW;
        end

        // Rank the candidate against every history entry.
        S_SEL_SW: begin
          if (idx_r != n_r) begin
            idx_r <= idx_r + 1'b1;
            rv1_r <= 1'b1;
          end else begin
            rv1_r <= 1'b0;
          end
          if (rv1_r) begin
            if (mem_q_r < cand_r) lt_r <= lt_r + 1'b1;
            if (mem_q_r <= cand_r) le_r <= le_r + 1'b1;
          end
          if ((idx_r == n_r) && !rv1_r) begin
            if (sel_hit) begin
              pv_r    <= {cand_r, 8'd0};
              state_r <= S_OUT;
            end else begin
              i_r     <= i_r + 1'b1;
              state_r <= S_SEL_C;
            end
          end
        end

        // Hand the report to the output register once it is free.
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r                 <= 1'b1;
            out_data_r.sample_count     <= cnt_r;
            out_data_r.sample_total     <= tot_r;
            out_data_r.smallest         <= min_r;
            out_data_r.largest          <= max_r;
            out_data_r.average          <= avg_r;
            out_data_r.deviation        <= dev_r;
            out_data_r.percentile_value <= pv_r;
            state_r                     <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // History fill never passes the effective size.
  assert property (@(posedge clk) disable iff (!rst_n) fill_r <= size_eff)
    else $error("history fill exceeds history size");

  // Write position stays inside the ring while history is enabled.
  assert property (@(posedge clk) disable iff (!rst_n)
    (size_eff != '0) |-> (wp_r < size_eff))
    else $error("write position outside ring");

  // A result only appears from the output state.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result raised outside output state");

  // The divider and the square root unit are quiet whenever the block takes transactions.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (dcnt_r == '0) && (scnt_r == '0))
    else $error("arithmetic unit busy while idle");

endmodule
